// ===== src/highest_response_ratio_picker_assert.svh =====
// Assertion macros used by the highest response ratio picker.
`ifndef HIGHEST_RESPONSE_RATIO_PICKER_ASSERT_SVH
`define HIGHEST_RESPONSE_RATIO_PICKER_ASSERT_SVH

`ifndef SYNTH

`define HRRP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define HRRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define HRRP_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define HRRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/hrrp_pkg.sv =====
`timescale 1ns / 1ps

package hrrp_pkg;

    localparam logic KIND_UPDATE   = 1'b0;
    localparam logic KIND_SCHEDULE = 1'b1;

    localparam logic [15:0] HALVED_RUN_TIME  = 16'd200;
    localparam logic [15:0] HALVED_RUN_VALUE = 16'd100;

    typedef struct packed {
        logic        kind;
        logic [3:0]  query_index;
        logic        eligible;
        logic [15:0] exec_len;
        logic [31:0] tick_now;
    } t_req;

    typedef struct packed {
        logic [3:0] chosen_query;
        logic       none_chosen;
    } t_rsp;

    typedef struct packed {
        logic        calc;
        logic        running;
        logic        upd_we;
        logic        stop_we;
        logic        elig;
        logic [15:0] exec_len;
    } t_cell_ctl;

    function automatic logic [15:0] scored_rt(input logic [15:0] rt);
        logic [15:0] res;
        begin
            if (rt == HALVED_RUN_TIME) begin
                res = HALVED_RUN_VALUE;
            end else if (rt == 16'd0) begin
                res = 16'd1;
            end else begin
                res = rt;
            end
            return res;
        end
    endfunction

endpackage

// ===== src/hrrp_cell.sv =====
`timescale 1ns / 1ps

module hrrp_cell
    import hrrp_pkg::*;
#(
    parameter int TIME_BITS = 32,
    parameter int IDX_W     = 4,
    parameter int CELL_IDX  = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic                 i_tok_valid,
    input  logic                 i_tok_have,
    input  logic [IDX_W-1:0]     i_tok_idx,
    input  logic [TIME_BITS-1:0] i_tok_wait,
    input  logic [15:0]          i_tok_rt,
    output logic                 o_tok_valid,
    output logic                 o_tok_have,
    output logic [IDX_W-1:0]     o_tok_idx,
    output logic [TIME_BITS-1:0] o_tok_wait,
    output logic [15:0]          o_tok_rt,
    output logic                 o_eligible
);

    localparam int PW = TIME_BITS + 16;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                 r_elig;
    logic [15:0]          r_rt;
    logic [TIME_BITS-1:0] r_stop;
    logic [TIME_BITS-1:0] r_wait;
    logic                 r_tok_valid;
    logic                 r_tok_have;
    logic [IDX_W-1:0]     r_tok_idx;
    logic [TIME_BITS-1:0] r_tok_wait;
    logic [15:0]          r_tok_rt;

    logic [15:0] rt_s;
    logic [PW-1:0] lhs;
    logic [PW-1:0] rhs;
    logic win;

    always_comb begin
        rt_s = scored_rt(r_rt);
        lhs  = PW'(r_wait) * PW'(i_tok_rt);
        rhs  = PW'(i_tok_wait) * PW'(rt_s);
        win  = r_elig && (lhs > rhs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elig      <= 1'b0;
            r_rt        <= 16'd1;
            r_stop      <= '0;
            r_tok_valid <= 1'b0;
        end else begin
            if (i_ctl.upd_we) begin
                r_elig <= i_ctl.elig;
                r_rt   <= i_ctl.exec_len;
            end
            if (i_ctl.stop_we) begin
                r_stop <= i_now;
            end
            r_tok_valid <= i_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.calc) begin
            r_wait <= i_ctl.running ? '0 : i_now - r_stop;
        end
        if (i_tok_valid) begin
            if (win) begin
                r_tok_have <= 1'b1;
                r_tok_idx  <= MY_IDX;
                r_tok_wait <= r_wait;
                r_tok_rt   <= rt_s;
            end else begin
                r_tok_have <= i_tok_have;
                r_tok_idx  <= i_tok_idx;
                r_tok_wait <= i_tok_wait;
                r_tok_rt   <= i_tok_rt;
            end
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok_have  = r_tok_have;
    assign o_tok_idx   = r_tok_idx;
    assign o_tok_wait  = r_tok_wait;
    assign o_tok_rt    = r_tok_rt;
    assign o_eligible  = r_elig;

endmodule

// ===== src/highest_response_ratio_picker.sv =====
`timescale 1ns / 1ps

// Channel   Valid        Stall        Payload
// request   i_in_valid   o_in_stall   i_req (t_req)
// result    o_out_valid  i_out_stall  o_rsp (t_rsp)
//
// An update request writes its entry at the edge that accepts it.
// A schedule request gives its result after these steps, in order:
// every cell forms its waiting time, the best candidate walks down the chain
// through a register in each cell, the winner is captured, and the choice and
// stop times are committed. Requests are stalled from a schedule acceptance
// until its commit; a stalled result delays the commit. Reset is synchronous
// and clears the whole table.

`include "highest_response_ratio_picker_assert.svh"

module highest_response_ratio_picker
    import hrrp_pkg::*;
#(
    parameter int NUM_QUERIES = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_rsp
);

    localparam int IDX_W = $clog2(NUM_QUERIES);

    logic                 r_busy;
    logic                 r_start;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_run_valid;
    logic [IDX_W-1:0]     r_run_q;
    logic                 r_tok_valid;
    logic                 r_tok_have;
    logic [IDX_W-1:0]     r_tok_idx;
    logic                 r_fin_valid;
    logic                 r_fin_have;
    logic [IDX_W-1:0]     r_fin_idx;
    logic                 r_out_valid;
    t_rsp                 r_out;

    logic                 in_acc;
    logic                 upd_acc;
    logic                 sch_acc;
    logic [63:0]          now_ext;
    logic [TIME_BITS-1:0] now_t;
    logic [31:0]          idx_ext;
    logic                 in_range;
    logic [IDX_W-1:0]     upd_idx;
    logic                 run_ok;
    logic                 commit;
    logic                 stop_any;
    logic [31:0]          fin_ext;

    logic [NUM_QUERIES-1:0] elig_vec;
    logic                   tv    [NUM_QUERIES+1];
    logic                   thave [NUM_QUERIES+1];
    logic [IDX_W-1:0]       tidx  [NUM_QUERIES+1];
    logic [TIME_BITS-1:0]   twait [NUM_QUERIES+1];
    logic [15:0]            trt   [NUM_QUERIES+1];

    always_comb begin
        in_acc   = i_in_valid && !r_busy;
        upd_acc  = in_acc && (i_req.kind == KIND_UPDATE);
        sch_acc  = in_acc && (i_req.kind == KIND_SCHEDULE);
        now_ext  = 64'(i_req.tick_now);
        now_t    = now_ext[TIME_BITS-1:0];
        idx_ext  = 32'(i_req.query_index);
        in_range = idx_ext < 32'(NUM_QUERIES);
        upd_idx  = idx_ext[IDX_W-1:0];
        run_ok   = r_run_valid && elig_vec[r_run_q];
        commit   = r_fin_valid && (!r_out_valid || !i_out_stall);
        stop_any = commit && r_run_valid && (!r_fin_have || (r_fin_idx != r_run_q));
        fin_ext  = 32'(r_fin_idx);
    end

    assign tv[0]    = r_tok_valid;
    assign thave[0] = r_tok_have;
    assign tidx[0]  = r_tok_idx;
    assign twait[0] = '0;
    assign trt[0]   = 16'd1;

    for (genvar k = 0; k < NUM_QUERIES; k++) begin : g_cell
        t_cell_ctl ctl;

        always_comb begin
            ctl.calc     = r_start;
            ctl.running  = r_run_valid && (r_run_q == IDX_W'(k));
            ctl.upd_we   = upd_acc && in_range && (upd_idx == IDX_W'(k));
            ctl.stop_we  = stop_any && (r_run_q == IDX_W'(k));
            ctl.elig     = i_req.eligible;
            ctl.exec_len = i_req.exec_len;
        end

        hrrp_cell #(
            .TIME_BITS (TIME_BITS),
            .IDX_W     (IDX_W),
            .CELL_IDX  (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_now       (r_now),
            .i_tok_valid (tv[k]),
            .i_tok_have  (thave[k]),
            .i_tok_idx   (tidx[k]),
            .i_tok_wait  (twait[k]),
            .i_tok_rt    (trt[k]),
            .o_tok_valid (tv[k+1]),
            .o_tok_have  (thave[k+1]),
            .o_tok_idx   (tidx[k+1]),
            .o_tok_wait  (twait[k+1]),
            .o_tok_rt    (trt[k+1]),
            .o_eligible  (elig_vec[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_run_valid <= 1'b0;
            r_run_q     <= '0;
            r_tok_valid <= 1'b0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start     <= sch_acc;
            r_tok_valid <= r_start;
            if (sch_acc) begin
                r_busy <= 1'b1;
            end
            if (tv[NUM_QUERIES]) begin
                r_fin_valid <= 1'b1;
            end
            if (commit) begin
                r_fin_valid <= 1'b0;
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
                r_run_valid <= r_fin_have;
                if (r_fin_have) begin
                    r_run_q <= r_fin_idx;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sch_acc) begin
            r_now <= now_t;
        end
        if (r_start) begin
            r_tok_have <= run_ok;
            r_tok_idx  <= r_run_q;
        end
        if (tv[NUM_QUERIES]) begin
            r_fin_have <= thave[NUM_QUERIES];
            r_fin_idx  <= tidx[NUM_QUERIES];
        end
        if (commit) begin
            if (r_fin_have) begin
                r_out.chosen_query <= fin_ext[3:0];
                r_out.none_chosen  <= 1'b0;
            end else begin
                r_out.chosen_query <= 4'd0;
                r_out.none_chosen  <= 1'b1;
            end
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_out;

    `HRRP_ASSERT_SAME(a_fin_only_busy, i_clk, i_rst_n, r_fin_valid, r_busy)
    `HRRP_ASSERT_SAME(a_sched_chain_empty, i_clk, i_rst_n, sch_acc,
                      !r_fin_valid && !r_tok_valid && !r_start)
    `HRRP_ASSERT_NEXT(a_commit_frees, i_clk, i_rst_n, commit, !r_busy && r_out_valid)
    `HRRP_ASSERT_SAME(a_none_is_zero, i_clk, i_rst_n, r_out_valid && r_out.none_chosen,
                      r_out.chosen_query == 4'd0)

endmodule

// ===== dv/tb_highest_response_ratio_picker.sv =====
`timescale 1ns / 1ps

module tb_highest_response_ratio_picker;
    import hrrp_pkg::*;

    localparam int QUERY_COUNT = 16;
    localparam int RANDOM_REQUESTS = 600;

    class pick_tracker;
        logic [31:0] stop_at [QUERY_COUNT];
        logic [15:0] run_len [QUERY_COUNT];
        logic        ready [QUERY_COUNT];
        logic [3:0]  cur_query;
        logic        cur_valid;
        t_rsp        expected_picks [$];
        int          errors;

        function new();
            for (int i = 0; i < QUERY_COUNT; i++) begin
                stop_at[i] = '0;
                run_len[i] = 16'd1;
                ready[i] = 1'b0;
            end
            cur_query = '0;
            cur_valid = 1'b0;
            errors = 0;
        endfunction

        // Scores every eligible entry and updates the running query and stop times.
        function t_rsp predict_pick(logic [31:0] now);
            logic [63:0] best_wait;
            logic [63:0] best_len;
            logic [63:0] waited;
            logic [63:0] len_v;
            logic [31:0] gap;
            logic        found;
            logic [3:0]  winner;
            t_rsp        pick;
            found = cur_valid && ready[cur_query];
            winner = found ? cur_query : 4'd0;
            best_wait = '0;
            best_len = 64'd1;
            for (int i = 0; i < QUERY_COUNT; i++) begin
                if (ready[i]) begin
                    gap = now - stop_at[i];
                    waited = (cur_valid && i == cur_query) ? 64'd0 : {32'd0, gap};
                    if (run_len[i] == 16'd200) begin
                        len_v = 64'd100;
                    end else if (run_len[i] == 16'd0) begin
                        len_v = 64'd1;
                    end else begin
                        len_v = {48'd0, run_len[i]};
                    end
                    if (waited * best_len > best_wait * len_v) begin
                        best_wait = waited;
                        best_len = len_v;
                        winner = i[3:0];
                        found = 1'b1;
                    end
                end
            end
            if (cur_valid && (!found || winner != cur_query)) begin
                stop_at[cur_query] = now;
            end
            if (found) begin
                cur_query = winner;
                cur_valid = 1'b1;
                pick.chosen_query = winner;
                pick.none_chosen = 1'b0;
            end else begin
                cur_valid = 1'b0;
                pick.chosen_query = 4'd0;
                pick.none_chosen = 1'b1;
            end
            return pick;
        endfunction

        function void note_request(t_req r);
            if (r.kind == KIND_UPDATE) begin
                ready[r.query_index] = r.eligible;
                run_len[r.query_index] = r.exec_len;
            end else begin
                expected_picks.push_back(predict_pick(r.tick_now));
            end
        endfunction

        task report_mismatch(string what);
            $display("%0t ns: mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_pick(t_rsp got);
            t_rsp want;
            if (expected_picks.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d/%0b",
                                          got.chosen_query, got.none_chosen));
            end else begin
                want = expected_picks.pop_front();
                if (got.chosen_query !== want.chosen_query) begin
                    report_mismatch($sformatf("chosen_query got %0d expected %0d",
                                              got.chosen_query, want.chosen_query));
                end
                if (got.none_chosen !== want.none_chosen) begin
                    report_mismatch($sformatf("none_chosen got %0b expected %0b",
                                              got.none_chosen, want.none_chosen));
                end
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_req req = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_rsp rsp;

    pick_tracker tracker;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          stall_left = 0;
    int          elig_pct = 75;
    logic [31:0] time_cursor = '0;

    highest_response_ratio_picker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_req       (req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_rsp       (rsp)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                tracker.check_pick(rsp);
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 11);
            end
            out_stall <= (stall_left > 0);
        end
    end

    task send_request(t_req r);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        req <= r;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        tracker.note_request(r);
    endtask

    task send_update(logic [3:0] idx, logic elig, logic [15:0] rt);
        t_req r;
        r.kind = KIND_UPDATE;
        r.query_index = idx;
        r.eligible = elig;
        r.exec_len = rt;
        r.tick_now = $urandom;
        send_request(r);
    endtask

    task send_schedule(logic [31:0] now);
        t_req r;
        r.kind = KIND_SCHEDULE;
        r.query_index = 4'($urandom_range(0, 15));
        r.eligible = 1'($urandom_range(0, 1));
        r.exec_len = 16'($urandom_range(0, 65535));
        r.tick_now = now;
        send_request(r);
    endtask

    task wait_for_picks();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.expected_picks.size() != 0);
    endtask

    function t_req random_request();
        t_req r;
        int   sel;
        r.kind = ($urandom_range(0, 99) < 40) ? KIND_SCHEDULE : KIND_UPDATE;
        r.query_index = 4'($urandom_range(0, 15));
        r.eligible = ($urandom_range(0, 99) < elig_pct);
        case ($urandom_range(0, 9))
            0: r.exec_len = 16'd200;
            1: r.exec_len = 16'd100;
            2: r.exec_len = 16'd0;
            3: r.exec_len = 16'hFFFF;
            4, 5: r.exec_len = 16'($urandom_range(0, 65535));
            default: r.exec_len = 16'($urandom_range(1, 40));
        endcase
        if (r.kind == KIND_SCHEDULE) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                time_cursor = $urandom;
            end else if (sel == 1) begin
                time_cursor = 32'hFFFF_FF00 + $urandom_range(0, 255);
            end else if (sel > 2) begin
                time_cursor = time_cursor + $urandom_range(1, 3000);
            end
            r.tick_now = time_cursor;
        end else begin
            r.tick_now = $urandom;
        end
        return r;
    endfunction

    initial begin
        tracker = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_schedule(32'd0);
        send_update(4'd0, 1'b1, 16'd1);
        send_update(4'd1, 1'b1, 16'd200);
        send_update(4'd2, 1'b1, 16'd100);
        send_update(4'd3, 1'b1, 16'd0);
        send_update(4'd15, 1'b1, 16'hFFFF);
        send_schedule(32'd1000);
        send_schedule(32'd1000);
        send_schedule(32'd1000);
        // The running query loses eligibility before the next decision.
        send_update(4'd1, 1'b0, 16'd200);
        send_schedule(32'd1000);
        send_update(4'd0, 1'b0, 16'd1);
        send_update(4'd2, 1'b0, 16'd100);
        send_update(4'd3, 1'b0, 16'd0);
        send_update(4'd15, 1'b0, 16'hFFFF);
        send_update(4'd5, 1'b1, 16'd7);
        send_schedule(32'd5000);
        send_schedule(32'd5000);
        send_update(4'd6, 1'b1, 16'd3);
        send_schedule(32'hFFFF_FFFF);
        // The waiting time of the outgoing query wraps around zero here.
        send_schedule(32'd100);
        send_update(4'd5, 1'b0, 16'd7);
        send_update(4'd6, 1'b0, 16'd3);
        send_schedule(32'd200);
        wait_for_picks();

        time_cursor = 32'd200;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            tx_idle_on = !((i >= 200 && i < 260) || i >= RANDOM_REQUESTS - 100);
            rx_idle_on = tx_idle_on;
            elig_pct = (i >= 330 && i < 390) ? 20 : 75;
            if (i == 300) begin
                wait_for_picks();
            end
            send_request(random_request());
        end
        wait_for_picks();
        repeat (40) @(posedge i_clk);

        if (tracker.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== highest_response_ratio_picker.f =====
+incdir+src
src/hrrp_pkg.sv
src/hrrp_cell.sv
src/highest_response_ratio_picker.sv
dv/tb_highest_response_ratio_picker.sv
